### hdl/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int QUAT_FRAC_BITS_DEF = 30;
  localparam int QUAT_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH    = 3;

  // The second product is built from a low slice of this many bits and a high slice.
  localparam int SPLIT_BITS = 16;

  typedef logic [CFG_INDEX_WIDTH-1:0] qvr_reg_idx_t;

  localparam qvr_reg_idx_t REG_QUAT_X = 3'd0;
  localparam qvr_reg_idx_t REG_QUAT_Y = 3'd1;
  localparam qvr_reg_idx_t REG_QUAT_Z = 3'd2;
  localparam qvr_reg_idx_t REG_QUAT_W = 3'd3;

  // Load enables for the two stages inside each split multiplier.
  typedef struct packed {
    logic pp;
    logic prod;
  } qvr_adv_t;

endpackage

### hdl/qvr_mul.sv
`timescale 1ns / 1ps

module qvr_mul #(
  parameter int AW = 36
) (
  input  logic                                            clk,
  input  qvr_pkg::qvr_adv_t                               adv,
  input  logic signed [AW-1:0]                            a,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]           b,
  output logic signed [AW+qvr_pkg::QUAT_WIDTH-1:0]        prod
);
  import qvr_pkg::*;

  localparam int PW  = AW + QUAT_WIDTH;
  localparam int LOW = SPLIT_BITS;
  localparam int HW  = AW - LOW;
  localparam int LPW = LOW + 1 + QUAT_WIDTH;
  localparam int HPW = HW + QUAT_WIDTH;

  logic signed [LOW:0]    a_lo;
  logic signed [HW-1:0]   a_hi;
  logic signed [LPW-1:0]  pp_lo;
  logic signed [HPW-1:0]  pp_hi;

  // The low slice is unsigned, so it gets a zero sign bit.
  assign a_lo = {1'b0, a[LOW-1:0]};
  assign a_hi = a[AW-1:LOW];

  always_ff @(posedge clk) begin
    if (adv.pp) begin
      pp_lo <= LPW'(a_lo) * LPW'(b);
      pp_hi <= HPW'(a_hi) * HPW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      prod <= (PW'(pp_hi) <<< LOW) + PW'(pp_lo);
    end
  end

endmodule

### hdl/quaternion_vector_rotate_unit.sv
`timescale 1ns / 1ps
// Throughput: one vector per cycle while the output is not stalled; each of the six
// stages holds one item, the multiplier stages (twelve products for q*v, twelve split
// products for t*conj(q)) set it.
// Reset (rst, synchronous): empties the pipeline and loads the identity quaternion.
// The configuration port is always ready; writes to an unknown index are dropped.

module quaternion_vector_rotate_unit #(
  parameter int COORD_WIDTH    = qvr_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]         cfg_data,
  input  logic                                   vec_valid,
  output logic                                   vec_stall,
  input  logic signed [COORD_WIDTH-1:0]          vec_x,
  input  logic signed [COORD_WIDTH-1:0]          vec_y,
  input  logic signed [COORD_WIDTH-1:0]          vec_z,
  output logic                                   rot_valid,
  input  logic                                   rot_stall,
  output logic signed [COORD_WIDTH-1:0]          rot_x,
  output logic signed [COORD_WIDTH-1:0]          rot_y,
  output logic signed [COORD_WIDTH-1:0]          rot_z,
  output logic                                   saturated
);
  import qvr_pkg::*;

  localparam int F      = QUAT_FRAC_BITS;
  localparam int PW     = COORD_WIDTH + QUAT_WIDTH;
  localparam int SW1    = PW + 2;
  localparam int TW     = SW1 - F;
  localparam int P2W    = TW + QUAT_WIDTH;
  localparam int SW2    = P2W + 2;
  localparam int RW     = SW2 - F;
  localparam int NSTAGE = 6;
  localparam int NMUL   = 12;

  localparam logic signed [SW1-1:0] HALF1 = SW1'(1) << (F - 1);
  localparam logic signed [SW2-1:0] HALF2 = SW2'(1) << (F - 1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [QUAT_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  logic signed [PW-1:0] p_xw, p_zy, p_yz, p_yw, p_zx, p_xz, p_zw, p_yx, p_xy, p_xx, p_yy, p_zz;
  logic signed [SW1-1:0] sum_tx, sum_ty, sum_tz, sum_tw;
  logic signed [TW-1:0]  t_x, t_y, t_z, t_w;

  logic signed [TW-1:0]         mul_a [NMUL];
  logic signed [QUAT_WIDTH-1:0] mul_b [NMUL];
  logic signed [P2W-1:0]        mul_p [NMUL];
  qvr_adv_t                     mul_adv;

  logic signed [SW2-1:0] sum_r [3];
  logic signed [RW-1:0]  r_val [3];

  logic [COORD_WIDTH:0] clip_x, clip_y, clip_z;
  logic                 in_acc, out_acc;

  function automatic logic [COORD_WIDTH:0] clip_fn(input logic signed [RW-1:0] v);
    logic over_hi;
    logic over_lo;
    logic [COORD_WIDTH-1:0] res;
    over_hi = !v[RW-1] && (|v[RW-2:COORD_WIDTH-1]);
    over_lo = v[RW-1] && !(&v[RW-2:COORD_WIDTH-1]);
    priority if (over_hi) begin
      res = COORD_MAX;
    end else if (over_lo) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_WIDTH-1:0];
    end
    return {over_hi || over_lo, res};
  endfunction

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_WIDTH'(1) << F;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        REG_QUAT_W: quat_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on too,
  // so bubbles close up behind a stalled result.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !rot_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vec_stall = !en[0];
  assign rot_valid = vld[NSTAGE-1];
  assign in_acc    = vec_valid && !vec_stall;
  assign out_acc   = rot_valid && !rot_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= vec_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: the twelve products of q * (v, 0)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_xw <= PW'(vec_x) * PW'(quat_w);
      p_zy <= PW'(vec_z) * PW'(quat_y);
      p_yz <= PW'(vec_y) * PW'(quat_z);
      p_yw <= PW'(vec_y) * PW'(quat_w);
      p_zx <= PW'(vec_z) * PW'(quat_x);
      p_xz <= PW'(vec_x) * PW'(quat_z);
      p_zw <= PW'(vec_z) * PW'(quat_w);
      p_yx <= PW'(vec_y) * PW'(quat_x);
      p_xy <= PW'(vec_x) * PW'(quat_y);
      p_xx <= PW'(vec_x) * PW'(quat_x);
      p_yy <= PW'(vec_y) * PW'(quat_y);
      p_zz <= PW'(vec_z) * PW'(quat_z);
    end
  end

  // Stage 1: sum and round to t, which is kept at full width
  assign sum_tx = SW1'(p_xw) + SW1'(p_zy) - SW1'(p_yz) + HALF1;
  assign sum_ty = SW1'(p_yw) - SW1'(p_zx) + SW1'(p_xz) + HALF1;
  assign sum_tz = SW1'(p_zw) + SW1'(p_yx) - SW1'(p_xy) + HALF1;
  assign sum_tw = HALF1 - SW1'(p_xx) - SW1'(p_yy) - SW1'(p_zz);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_x <= sum_tx[SW1-1:F];
      t_y <= sum_ty[SW1-1:F];
      t_z <= sum_tz[SW1-1:F];
      t_w <= sum_tw[SW1-1:F];
    end
  end

  // Stages 2 and 3: t * conj(q). Each output axis takes four products in the
  // order (t_axis * w, t_w * q_axis, first cross term, second cross term).
  always_comb begin
    mul_a[0]  = t_x; mul_b[0]  = quat_w;
    mul_a[1]  = t_w; mul_b[1]  = quat_x;
    mul_a[2]  = t_z; mul_b[2]  = quat_y;
    mul_a[3]  = t_y; mul_b[3]  = quat_z;
    mul_a[4]  = t_y; mul_b[4]  = quat_w;
    mul_a[5]  = t_w; mul_b[5]  = quat_y;
    mul_a[6]  = t_x; mul_b[6]  = quat_z;
    mul_a[7]  = t_z; mul_b[7]  = quat_x;
    mul_a[8]  = t_z; mul_b[8]  = quat_w;
    mul_a[9]  = t_w; mul_b[9]  = quat_z;
    mul_a[10] = t_y; mul_b[10] = quat_x;
    mul_a[11] = t_x; mul_b[11] = quat_y;
  end

  assign mul_adv.pp   = en[2];
  assign mul_adv.prod = en[3];

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    qvr_mul #(
      .AW (TW)
    ) u_mul (
      .clk  (clk),
      .adv  (mul_adv),
      .a    (mul_a[i]),
      .b    (mul_b[i]),
      .prod (mul_p[i])
    );
  end

  // Stage 4: sum and round each axis
  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign sum_r[k] = SW2'(mul_p[4*k]) - SW2'(mul_p[4*k+1])
                    + SW2'(mul_p[4*k+2]) - SW2'(mul_p[4*k+3]) + HALF2;

    always_ff @(posedge clk) begin
      if (en[4]) begin
        r_val[k] <= sum_r[k][SW2-1:F];
      end
    end
  end

  // Stage 5: saturate into the output register
  assign clip_x = clip_fn(r_val[0]);
  assign clip_y = clip_fn(r_val[1]);
  assign clip_z = clip_fn(r_val[2]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rot_x     <= clip_x[COORD_WIDTH-1:0];
      rot_y     <= clip_y[COORD_WIDTH-1:0];
      rot_z     <= clip_z[COORD_WIDTH-1:0];
      saturated <= clip_x[COORD_WIDTH] || clip_y[COORD_WIDTH] || clip_z[COORD_WIDTH];
    end
  end

`ifndef SYNTHESIS
  // An empty pipeline always takes a new item.
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> !vec_stall)
    else $error("pipeline empty but input stalled");

  // Items in flight change only by what enters and what leaves.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) ==
              $past($countones(vld)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or duplicated in the pipeline");

  // The flag is only raised when some coordinate sits at a bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && saturated) |->
      (rot_x == COORD_MAX || rot_x == COORD_MIN || rot_y == COORD_MAX ||
       rot_y == COORD_MIN || rot_z == COORD_MAX || rot_z == COORD_MIN))
    else $error("saturated flag without a clipped coordinate");
`endif

endmodule

### verif/quaternion_vector_rotate_unit_tb.sv
`timescale 1ns / 1ps

module quaternion_vector_rotate_unit_tb;
  import qvr_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int QF = QUAT_FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_INDEXES = 1 << CFG_INDEX_WIDTH;
  // cos(45 degrees) in Q1.30.
  localparam logic signed [31:0] C45 = 32'sd759250125;
  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< QF;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [127:0] acc_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [QUAT_WIDTH-1:0] qcomp_t;

  localparam acc_t HALF_LSB = 128'sd1 <<< (QF - 1);
  localparam acc_t ACC_MAX = acc_t'(C_MAX);
  localparam acc_t ACC_MIN = acc_t'(C_MIN);

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  qvr_reg_idx_t cfg_index = '0;
  logic [QUAT_WIDTH-1:0] cfg_data = '0;
  logic vec_valid = 1'b0;
  logic vec_stall;
  coord_t vec_x = '0;
  coord_t vec_y = '0;
  coord_t vec_z = '0;
  logic rot_valid;
  logic rot_stall = 1'b0;
  coord_t rot_x;
  coord_t rot_y;
  coord_t rot_z;
  logic saturated;

  quaternion_vector_rotate_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .vec_valid(vec_valid),
    .vec_stall(vec_stall),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .rot_valid(rot_valid),
    .rot_stall(rot_stall),
    .rot_x(rot_x),
    .rot_y(rot_y),
    .rot_z(rot_z),
    .saturated(saturated)
  );

  // The quaternion as the block should currently hold it.
  qcomp_t q_x = '0, q_y = '0, q_z = '0, q_w = Q_ONE;

  rotated_t rot_expected[$];
  bit gaps_on = 1'b1;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  function automatic acc_t round_q(acc_t s);
    return (s + HALF_LSB) >>> QF;
  endfunction

  function automatic coord_t clip_coord(acc_t v, ref logic sat);
    if (v > ACC_MAX) begin
      sat = 1'b1;
      return C_MAX;
    end
    if (v < ACC_MIN) begin
      sat = 1'b1;
      return C_MIN;
    end
    return coord_t'(v);
  endfunction

  // q * (v, 0) * conj(q), each sum of products rounded to nearest, final clip.
  function automatic rotated_t rotate_by_quat(coord_t x, coord_t y, coord_t z);
    acc_t vx = x, vy = y, vz = z;
    acc_t qx = q_x, qy = q_y, qz = q_z, qw = q_w;
    acc_t tx, ty, tz, tw;
    rotated_t r;
    logic sat = 1'b0;
    tx = round_q(vx * qw + vz * qy - vy * qz);
    ty = round_q(vy * qw - vz * qx + vx * qz);
    tz = round_q(vz * qw + vy * qx - vx * qy);
    tw = round_q(-(vx * qx) - vy * qy - vz * qz);
    r.x = clip_coord(round_q(tx * qw - tw * qx + tz * qy - ty * qz), sat);
    r.y = clip_coord(round_q(ty * qw - tw * qy + tx * qz - tz * qx), sat);
    r.z = clip_coord(round_q(tz * qw - tw * qz + ty * qx - tx * qy), sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [CW-1:0] exp_v,
                             logic signed [CW-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    rotated_t e;
    if (!rst && rot_valid && !rot_stall) begin
      results_seen++;
      if (saturated === 1'b1) sat_seen++;
      if (rot_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, rot_x, rot_y, rot_z);
      end else begin
        e = rot_expected.pop_front();
        check_field("rot_x", e.x, rot_x);
        check_field("rot_y", e.y, rot_y);
        check_field("rot_z", e.z, rot_z);
        check_field("saturated", e.sat, saturated);
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk) begin
    rot_stall <= gaps_on && ($urandom_range(0, 99) < 17);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if ((vec_valid && !vec_stall) || (rot_valid && !rot_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_vec(coord_t x, coord_t y, coord_t z);
    // Each idle cycle is drawn on its own, with a chance of 17 in 100 while gaps are on.
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    rot_expected.push_back(rotate_by_quat(x, y, z));
    items_sent++;
  endtask

  // Stop sending and let the pipeline empty out.
  task automatic drain;
    vec_valid <= 1'b0;
    while (rot_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(qvr_reg_idx_t idx, logic [QUAT_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_QUAT_X: q_x = data;
      REG_QUAT_Y: q_y = data;
      REG_QUAT_Z: q_z = data;
      REG_QUAT_W: q_w = data;
      default: ;
    endcase
  endtask

  task automatic load_quat(qcomp_t x, qcomp_t y, qcomp_t z, qcomp_t w);
    drain();
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    write_reg(REG_QUAT_W, w);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 65535) - 32768);
      2: return coord_t'($urandom_range(0, 1 << 24) - (1 << 23));
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  // Identity quaternion from reset must pass every vector through unchanged.
  task automatic test_reset_identity;
    send_vec('0, '0, '0);
    send_vec(C_MAX, C_MIN, '1);
    send_vec(C_MIN, C_MIN, C_MIN);
    send_vec(C_MAX, C_MAX, C_MAX);
    send_vec(32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1);
  endtask

  task automatic test_rotations;
    // Quarter turn about z.
    load_quat('0, '0, C45, C45);
    send_vec(32'sd1000000, '0, 32'sd7);
    send_vec(C_MAX, C_MAX, C_MIN);
    send_vec(C_MIN, 32'sd12345, '1);
    // Half turn about x: negating the most negative coordinate has to clip.
    load_quat(Q_ONE, '0, '0, '0);
    send_vec(32'sd5, C_MIN, C_MAX);
    send_vec(32'sd5, C_MAX, 32'sd3);
    // Zero quaternion collapses everything to the origin.
    load_quat('0, '0, '0, '0);
    send_vec(C_MAX, C_MIN, 32'sd99);
  endtask

  // A scalar of one half makes intermediates from odd values land exactly on a half.
  task automatic test_rounding_ties;
    load_quat('0, '0, '0, Q_ONE >>> 1);
    send_vec(32'sd1, -32'sd1, 32'sd3);
    send_vec(-32'sd3, 32'sd5, -32'sd5);
    send_vec(32'sd7, -32'sd7, C_MIN);
  endtask

  // Non-unit quaternions scale the result and drive it into the rails.
  task automatic test_scaling_extremes;
    load_quat('0, '0, '0, 32'sh7FFF_FFFF);
    send_vec(32'sd1000, -32'sd1000, 32'sd1 <<< 29);
    send_vec(C_MAX, C_MIN, '0);
    load_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vec(32'sd1, -32'sd2, 32'sd3);
    load_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vec(32'sd1, 32'sd1, -32'sd1);
    send_vec(C_MIN, C_MAX, 32'sd0);
  endtask

  // Writes to indexes beyond the quaternion must leave it untouched.
  task automatic test_unused_indexes;
    load_quat(32'sd123456789, -32'sd98765432, 32'sd314159265, 32'sd600000000);
    for (int i = REG_QUAT_W + 1; i < NUM_INDEXES; i++)
      write_reg(qvr_reg_idx_t'(i), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_vec(32'sd1 <<< 20, -32'sd77, C_MAX);
  endtask

  task automatic test_random_stream;
    qcomp_t qx, qy, qz, qw;
    for (int p = 0; p < 7; p++) begin
      case (p % 3)
        0: begin
          qx = $urandom_range(0, 1 << 30) - (1 << 29);
          qy = $urandom_range(0, 1 << 30) - (1 << 29);
          qz = $urandom_range(0, 1 << 30) - (1 << 29);
          qw = $urandom_range(0, 1 << 30) - (1 << 29);
        end
        1: begin
          qx = $urandom;
          qy = $urandom;
          qz = $urandom;
          qw = $urandom;
        end
        default: begin
          qx = $urandom_range(0, 1 << 28) - (1 << 27);
          qy = $urandom_range(0, 1 << 28) - (1 << 27);
          qz = $urandom_range(0, 1 << 28) - (1 << 27);
          qw = $urandom_range(1 << 29, 1 << 30);
        end
      endcase
      load_quat(qx, qy, qz, qw);
      // One long burst with no gaps on either side.
      gaps_on = (p != 3);
      for (int n = 0; n < 62; n++) begin
        send_vec(rand_coord(), rand_coord(), rand_coord());
        if (p == 1 && n == 30) begin
          vec_valid <= 1'b0;
          while (rot_expected.size() != 0) @(posedge clk);
        end
      end
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_rotations();
    test_rounding_ties();
    test_scaling_extremes();
    test_unused_indexes();
    test_random_stream();
    drain();
    if (rot_expected.size() != 0) begin
      errors += rot_expected.size();
      $display("%0t: %0d results never arrived", $time, rot_expected.size());
    end
    $display("summary: %0d vectors rotated under %0d quaternion settings,", items_sent,
             settings_used);
    $display("summary: %0d results compared, %0d of them clipped, %0d errors", results_seen,
             sat_seen, errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hdl/qvr_pkg.sv
hdl/qvr_mul.sv
hdl/quaternion_vector_rotate_unit.sv
verif/quaternion_vector_rotate_unit_tb.sv
